// File: sv/salf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package salf_pkg;

    // default geometry
    localparam int MAX_SETS_DEF   = 256;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 48;

    // fixed field widths
    localparam int TAG_MAX_W   = 48;
    localparam int AGE_W       = 32;
    localparam int CNT_W       = 32;
    localparam int OUT_W       = 3 + 4 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_OFFSET    = 2'd1;
    localparam logic [1:0] REG_SET_BITS  = 2'd2;
    localparam logic [1:0] REG_WAYS_USED = 2'd3;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic       POLICY_RST    = POLICY_FIFO;
    localparam logic [3:0] OFFSET_RST    = 4'd4;
    localparam logic [3:0] SET_BITS_RST  = 4'd0;
    localparam logic [3:0] WAYS_USED_RST = 4'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_RD,
        ST_CHK,
        ST_REPLACE,
        ST_DONE
    } salf_state_t;

endpackage

`default_nettype wire

// File: sv/set_assoc_cache_lru_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// tag-only set-associative cache with fifo or lru replacement
//
// input channel s_*: one access per transfer, s_tdata carries the byte address,
// s_tuser the access kind (0 read, 1 write)
// output channel m_*: one result per access, hit / mem_read / mem_write flags and
// the four running counters (hit, miss, memory read, write) after this access
// config: apb registers policy @0x0, offset_bits @0x4, set_bits @0x8, ways_used @0xc
//
// the ways of a set are looked at one at a time through the line ram read port:
// a read state and a check state per way; an access that examines n ways passes
// split, n read and check pairs, a replace state when a victim is replaced, and
// done before idle takes the next transfer; done loads the output register
// the valid-bit ram is cleared after reset, one set per cycle over every set,
// during which s_tready stays low; config writes are taken meanwhile
// a result waits in the output register while the receiver stalls; the next
// access is still taken and runs up to the point of handing over its result
module set_assoc_cache_lru_fifo
    import salf_pkg::*;
#(
    parameter int MAX_SETS   = MAX_SETS_DEF,
    parameter int MAX_WAYS   = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
    localparam int IN_TDATA_W = ((ADDR_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // access input
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // address
    input  wire logic                   s_tuser,   // kind
    // result output
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // hit, mem_read, mem_write,
                                                   // hit_total, miss_total,
                                                   // read_total, write_total
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int TAG_W    = (ADDR_WIDTH < TAG_MAX_W) ? ADDR_WIDTH : TAG_MAX_W;
    localparam int LINE_DW  = TAG_W + AGE_W;
    localparam int LINES    = MAX_SETS * MAX_WAYS;
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int LINE_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LOG_SETS = $clog2(MAX_SETS + 1) - 1;   // floor of log2

    // configuration registers
    logic       policy_reg;
    logic [3:0] offset_reg;
    logic [3:0] set_bits_reg;
    logic [3:0] ways_used_reg;

    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POLICY_RST;
            offset_reg    <= OFFSET_RST;
            set_bits_reg  <= SET_BITS_RST;
            ways_used_reg <= WAYS_USED_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_POLICY:    policy_reg    <= pwdata[0];
                REG_OFFSET:    offset_reg    <= pwdata[3:0];
                REG_SET_BITS:  set_bits_reg  <= pwdata[3:0];
                REG_WAYS_USED: ways_used_reg <= pwdata[3:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_POLICY:    prdata = {{(CFG_DATA_W-1){1'b0}}, policy_reg};
            REG_OFFSET:    prdata = {{(CFG_DATA_W-4){1'b0}}, offset_reg};
            REG_SET_BITS:  prdata = {{(CFG_DATA_W-4){1'b0}}, set_bits_reg};
            REG_WAYS_USED: prdata = {{(CFG_DATA_W-4){1'b0}}, ways_used_reg};
        endcase
    end

    // effective geometry: set bits capped to the sets present, ways clamped
    logic [3:0]       sb_eff;
    logic [4:0]       ways_eff;
    logic [4:0]       last_way5;
    logic [WAY_W-1:0] last_way;

    always_comb
    begin
        sb_eff = (set_bits_reg > 4'(LOG_SETS)) ? 4'(LOG_SETS) : set_bits_reg;
        if (ways_used_reg == 4'd0)
        begin
            ways_eff = 5'd1;
        end
        else if ({1'b0, ways_used_reg} > 5'(MAX_WAYS))
        begin
            ways_eff = 5'(MAX_WAYS);
        end
        else
        begin
            ways_eff = {1'b0, ways_used_reg};
        end
        last_way5 = ways_eff - 5'd1;
        last_way  = WAY_W'(last_way5);
    end

    // sequencer state
    salf_state_t state_reg, state_next;
    logic [SET_W-1:0]      clr_reg, clr_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic                  kind_reg, kind_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [WAY_W-1:0]      way_reg, way_next;
    logic [WAY_W-1:0]      best_way_reg, best_way_next;
    logic [AGE_W-1:0]      best_age_reg, best_age_next;
    logic                  hit_reg, hit_next;
    logic [AGE_W-1:0]      age_reg, age_next;
    logic [CNT_W-1:0]      hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]      miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]      wr_cnt_reg, wr_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg, out_hit_next;
    logic                  out_kind_reg, out_kind_next;

    // ram ports
    logic                line_we, line_re;
    logic [LINE_W-1:0]   line_waddr, line_raddr;
    logic [LINE_DW-1:0]  line_wdata, line_rdata;
    logic                v_we, v_re;
    logic [SET_W-1:0]    v_waddr;
    logic [MAX_WAYS-1:0] v_wdata, v_rdata;

    logic [WAY_W-1:0]    line_way;
    logic [TAG_W-1:0]    rd_tag;
    logic [AGE_W-1:0]    rd_age;
    logic [AGE_W-1:0]    stamp;
    logic [4:0]          tag_shamt;
    logic                out_free;

    assign rd_tag    = line_rdata[TAG_W-1:0];
    assign rd_age    = line_rdata[TAG_W +: AGE_W];
    assign stamp     = age_reg + AGE_W'(1);
    assign tag_shamt = {1'b0, offset_reg} + {1'b0, sb_eff};
    assign out_free  = !out_valid_reg || m_tready;

    // line address is set * MAX_WAYS + way
    assign line_way   = (state_reg == ST_REPLACE) ? best_way_reg : way_reg;
    assign line_waddr = LINE_W'(LINE_W'(set_reg) * LINE_W'(MAX_WAYS) + LINE_W'(line_way));
    assign line_raddr = LINE_W'(LINE_W'(set_reg) * LINE_W'(MAX_WAYS) + LINE_W'(way_reg));
    assign line_wdata = {stamp, tag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            age_reg       <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            age_reg       <= age_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers of the current access
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        kind_reg     <= kind_next;
        set_reg      <= set_next;
        tag_reg      <= tag_next;
        way_reg      <= way_next;
        best_way_reg <= best_way_next;
        best_age_reg <= best_age_next;
        hit_reg      <= hit_next;
        out_hit_reg  <= out_hit_next;
        out_kind_reg <= out_kind_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        kind_next      = kind_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        way_next       = way_reg;
        best_way_next  = best_way_reg;
        best_age_next  = best_age_reg;
        hit_next       = hit_reg;
        age_next       = age_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_kind_next  = out_kind_reg;
        line_we        = 1'b0;
        line_re        = 1'b0;
        v_we           = 1'b0;
        v_re           = 1'b0;
        v_waddr        = set_reg;
        v_wdata        = v_rdata | (MAX_WAYS'(1) << way_reg);
        s_tready       = (state_reg == ST_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // wipe the valid bits one set per cycle
                v_we     = 1'b1;
                v_waddr  = clr_reg;
                v_wdata  = '0;
                clr_next = clr_reg + SET_W'(1);
                if (clr_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next  = s_tdata[ADDR_WIDTH-1:0];
                    kind_next  = s_tuser;
                    state_next = ST_SPLIT;
                end
            end

            ST_SPLIT:
            begin
                set_next   = SET_W'(addr_reg >> offset_reg) & ~({SET_W{1'b1}} << sb_eff);
                tag_next   = TAG_W'(addr_reg >> tag_shamt);
                way_next   = '0;
                state_next = ST_RD;
            end

            ST_RD:
            begin
                line_re    = 1'b1;
                v_re       = 1'b1;
                state_next = ST_CHK;
            end

            ST_CHK:
            begin
                if (!v_rdata[way_reg])
                begin
                    // first empty way takes the line
                    line_we    = 1'b1;
                    v_we       = 1'b1;
                    age_next   = stamp;
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (rd_tag == tag_reg)
                begin
                    hit_next = 1'b1;
                    if (policy_reg == POLICY_LRU)
                    begin
                        line_we  = 1'b1;
                        age_next = stamp;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    // track the first way with the smallest stamp
                    if (way_reg == '0 || rd_age < best_age_reg)
                    begin
                        best_way_next = way_reg;
                        best_age_next = rd_age;
                    end
                    if (way_reg == last_way)
                    begin
                        state_next = ST_REPLACE;
                    end
                    else
                    begin
                        way_next   = way_reg + WAY_W'(1);
                        state_next = ST_RD;
                    end
                end
            end

            ST_REPLACE:
            begin
                line_we    = 1'b1;
                age_next   = stamp;
                hit_next   = 1'b0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    if (hit_reg)
                    begin
                        hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        miss_cnt_next = miss_cnt_reg + CNT_W'(1);
                        rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                    end
                    if (kind_reg)
                    begin
                        wr_cnt_next = wr_cnt_reg + CNT_W'(1);
                    end
                    out_hit_next   = hit_reg;
                    out_kind_next  = kind_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // tag and stamp of every line
    salf_ram #(
        .WIDTH (LINE_DW),
        .DEPTH (LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // one row of valid bits per set
    salf_ram #(
        .WIDTH (MAX_WAYS),
        .DEPTH (MAX_SETS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (set_reg),
        .rdata (v_rdata)
    );

    // counters only move when a result is loaded, so they double as the totals
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, wr_cnt_reg, rd_cnt_reg, miss_cnt_reg,
                       hit_cnt_reg, out_kind_reg, ~out_hit_reg, out_hit_reg};

    // the stamp source steps by at most one per cycle
    a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
        (age_reg == $past(age_reg)) || (age_reg == $past(age_reg) + AGE_W'(1)))
        else $error("age counter jumped");

    // line ram is only written while checking a way or replacing a victim
    a_line_we: assert property (@(posedge clk) disable iff (!rst_n)
        line_we |-> (state_reg == ST_CHK || state_reg == ST_REPLACE))
        else $error("line write outside lookup");

    // the way scan stays within the ways in use
    a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_CHK) |-> (way_reg <= last_way))
        else $error("way index beyond ways in use");

    // hit and miss totals stay put while a result waits
    a_hold_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> ($stable(hit_cnt_reg) && $stable(miss_cnt_reg)))
        else $error("totals changed under a stalled result");

    // each result is counted as exactly one hit or one miss
    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=>
            ((hit_cnt_reg != $past(hit_cnt_reg)) != (miss_cnt_reg != $past(miss_cnt_reg))))
        else $error("result not counted once");

endmodule

`default_nettype wire

// File: sv/salf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module salf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: dv/tb_set_assoc_cache_lru_fifo.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_fifo;
    import salf_pkg::*;

    localparam int LINE_COUNT   = MAX_SETS_DEF * MAX_WAYS_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
    localparam int LONG_HOLD    = 400;   // receiver back-pressure stretch

    // access kinds carried on s_tuser
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [47:0] addr;
    } access_t;

    typedef struct packed {
        logic        hit;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] read_total;
        logic [31:0] write_total;
    } lookup_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = ~clk;
    end

    // dut ports; the inputs are driven to known values from time zero
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [47:0]             s_tdata  = '0;   // address[47:0]
    logic                    s_tuser  = 1'b0; // kind
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;         // hit, mem_read, mem_write, hit_total,
                                              // miss_total, read_total, write_total
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    set_assoc_cache_lru_fifo uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // cache model: our own copy of the tags, valid bits, stamps and counters
    // ------------------------------------------------------------------
    logic        cfg_policy = POLICY_RST;
    logic [3:0]  cfg_offset = OFFSET_RST;
    logic [3:0]  cfg_set_bits = SET_BITS_RST;
    logic [3:0]  cfg_ways = WAYS_USED_RST;

    logic [47:0] line_tag   [LINE_COUNT];
    logic        line_valid [LINE_COUNT];
    logic [31:0] line_stamp [LINE_COUNT];
    logic [31:0] stamp_clock = '0;
    logic [31:0] hits_seen   = '0;
    logic [31:0] misses_seen = '0;
    logic [31:0] reads_seen  = '0;
    logic [31:0] writes_seen = '0;

    initial
    begin
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            line_valid[i] = 1'b0;
        end
    end

    // set index width actually used: too many set bits fall back to what fits
    function automatic int unsigned eff_set_bits(input logic [3:0] sb_cfg);
        int unsigned sb;
        sb = sb_cfg;
        while (sb > 0 && (1 << sb) > MAX_SETS_DEF)
        begin
            sb--;
        end
        return sb;
    endfunction

    // look one access up, update the model state and return the result
    function automatic lookup_result_t lookup_access(input logic kind, input logic [47:0] addr);
        int unsigned    sb;
        int unsigned    ways;
        int unsigned    base;
        int unsigned    victim;
        logic [63:0]    set_idx;
        logic [47:0]    tag;
        logic           hit;
        logic           filled;
        lookup_result_t res;
        sb = eff_set_bits(cfg_set_bits);
        // way count 0 acts as 1, above the maximum acts as the maximum
        ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cfg_ways);
        set_idx = ({16'b0, addr} >> cfg_offset) & ((64'd1 << sb) - 64'd1);
        tag = 48'({16'b0, addr} >> (cfg_offset + sb));
        base = int'(set_idx) * MAX_WAYS_DEF;
        hit = 1'b0;
        filled = 1'b0;
        // ways searched in order: first invalid way is filled, a tag match is a hit
        for (int unsigned w = 0; w < ways && !hit && !filled; w++)
        begin
            if (!line_valid[base + w])
            begin
                line_valid[base + w] = 1'b1;
                line_tag[base + w] = tag;
                stamp_clock = stamp_clock + 32'd1;
                line_stamp[base + w] = stamp_clock;
                filled = 1'b1;
            end
            else if (line_tag[base + w] == tag)
            begin
                if (cfg_policy == POLICY_LRU)
                begin
                    stamp_clock = stamp_clock + 32'd1;
                    line_stamp[base + w] = stamp_clock;
                end
                hit = 1'b1;
            end
        end
        // set full: the first way holding the smallest stamp is replaced
        if (!hit && !filled)
        begin
            victim = 0;
            for (int unsigned w = 1; w < ways; w++)
            begin
                if (line_stamp[base + w] < line_stamp[base + victim])
                begin
                    victim = w;
                end
            end
            line_tag[base + victim] = tag;
            stamp_clock = stamp_clock + 32'd1;
            line_stamp[base + victim] = stamp_clock;
        end
        if (hit)
        begin
            hits_seen = hits_seen + 32'd1;
        end
        else
        begin
            misses_seen = misses_seen + 32'd1;
            reads_seen = reads_seen + 32'd1;
        end
        if (kind == KIND_WRITE)
        begin
            writes_seen = writes_seen + 32'd1;
        end
        res.hit = hit;
        res.mem_read = !hit;
        res.mem_write = kind;
        res.hit_total = hits_seen;
        res.miss_total = misses_seen;
        res.read_total = reads_seen;
        res.write_total = writes_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping shared by the processes
    // ------------------------------------------------------------------
    access_t        pending_q [$];   // accesses not yet offered
    lookup_result_t result_q  [$];   // results the cache owes us, oldest first
    int             queued_count   = 0;
    int             accepted_count = 0;
    int             result_count   = 0;
    int             err_count      = 0;
    logic           long_hold_req  = 1'b0;

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        err_count++;
        $display("[%0t] result %0d: %0s mismatch, expected %0h got %0h",
                 $time, result_count, what, want, got);
    endtask

    task automatic queue_access(input logic kind, input logic [47:0] addr);
        access_t acc;
        acc.kind = kind;
        acc.addr = addr;
        pending_q.push_back(acc);
        queued_count++;
    endtask

    // wait until every queued access went in and every result came out,
    // then let the pipeline settle
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (accepted_count != queued_count || result_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup phase, then access phase until pready
    task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POLICY:    cfg_policy = value[0];
            REG_OFFSET:    cfg_offset = value;
            REG_SET_BITS:  cfg_set_bits = value;
            REG_WAYS_USED: cfg_ways = value;
            default:       ;
        endcase
    endtask

    // reprogram the whole geometry, only once the cache has gone quiet
    task automatic apply_cfg(input logic policy, input logic [3:0] offset,
                             input logic [3:0] set_bits, input logic [3:0] ways);
        wait_idle();
        write_reg(REG_POLICY, {3'b0, policy});
        write_reg(REG_OFFSET, offset);
        write_reg(REG_SET_BITS, set_bits);
        write_reg(REG_WAYS_USED, ways);
    endtask

    // random accesses around a hot region so that sets fill up, hit and evict;
    // a share of fully random addresses keeps every address bit moving
    task automatic run_random(input int n_items);
        logic [47:0] base;
        logic [47:0] addr;
        int unsigned tag_shift;
        int unsigned spread;
        base = 48'({$urandom(), $urandom()});
        tag_shift = cfg_offset + eff_set_bits(cfg_set_bits);
        spread = $urandom_range(2, 14);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                addr = 48'({$urandom(), $urandom()});
            end
            else
            begin
                addr = base
                     + (48'($urandom_range(0, spread)) << tag_shift)
                     + (48'($urandom_range(0, 3)) << cfg_offset)
                     + (48'($urandom()) & ((48'd1 << cfg_offset) - 48'd1));
            end
            queue_access(1'($urandom_range(0, 1)), addr);
        end
    endtask

    // ------------------------------------------------------------------
    // access driver: bursts of transfers separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge clk)
    begin : access_driver
        access_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                // the model runs in transfer order, so results queue up in order
                result_q.push_back(lookup_access(s_tuser, s_tdata));
                accepted_count++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.addr;
                    s_tuser  <= nxt.kind;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        // mostly short gaps, sometimes none, now and then a long one
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            9:       gap_left = $urandom_range(20, 40);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    int          hold_left  = 0;
    int          stall_mode = 0;
    logic [31:0] stall_tick = '0;

    always @(posedge clk)
    begin : result_monitor
        lookup_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (result_q.size() == 0)
                begin
                    report("unexpected transfer", 32'h0, m_tdata[31:0]);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report("hit", 32'(want.hit), 32'(m_tdata[0]));
                    if (m_tdata[1] !== want.mem_read)
                        report("mem_read", 32'(want.mem_read), 32'(m_tdata[1]));
                    if (m_tdata[2] !== want.mem_write)
                        report("mem_write", 32'(want.mem_write), 32'(m_tdata[2]));
                    if (m_tdata[34:3] !== want.hit_total)
                        report("hit_total", want.hit_total, m_tdata[34:3]);
                    if (m_tdata[66:35] !== want.miss_total)
                        report("miss_total", want.miss_total, m_tdata[66:35]);
                    if (m_tdata[98:67] !== want.read_total)
                        report("read_total", want.read_total, m_tdata[98:67]);
                    if (m_tdata[130:99] !== want.write_total)
                        report("write_total", want.write_total, m_tdata[130:99]);
                end
            end

            stall_tick = stall_tick + 32'd1;
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (stall_tick % 48 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end

            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       m_tready <= 1'b1;                      // never stalls
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= stall_tick[2];             // follows bit 2 of the tick count
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transfer on any port ends the run
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_set_assoc_cache_lru_fifo: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // random phases: policy, offset bits, set bits, ways used
    logic [3:0] phase_cfg [9][4] = '{
        '{4'd1, 4'd4,  4'd2,  4'd4},
        '{4'd0, 4'd0,  4'd0,  4'd8},
        '{4'd1, 4'd12, 4'd8,  4'd8},
        '{4'd0, 4'd15, 4'd15, 4'd15},
        '{4'd1, 4'd3,  4'd3,  4'd0},
        '{4'd0, 4'd6,  4'd1,  4'd2},
        '{4'd1, 4'd0,  4'd8,  4'd1},
        '{4'd0, 4'd12, 4'd4,  4'd8},
        '{4'd1, 4'd5,  4'd2,  4'd3}
    };

    // tags in set 0 that tell lru from fifo: a b c d go in, a again, e evicts, b again
    int unsigned age_probe [7] = '{1, 2, 3, 4, 1, 5, 2};

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: fifo, 16-byte blocks, one set, one way
        queue_access(KIND_READ,  48'h0);                // cold miss fills the way
        queue_access(KIND_WRITE, 48'h00f);              // same block, hit
        queue_access(KIND_WRITE, 48'hffff_ffff_ffff);   // conflict replaces it
        queue_access(KIND_READ,  48'hffff_ffff_fff0);   // hit on the new tag
        queue_access(KIND_READ,  48'h0);                // miss again

        // lru, byte blocks, 4 sets of 4 ways; old lines are kept under the new split
        apply_cfg(POLICY_LRU, 4'd0, 4'd2, 4'd4);
        for (int i = 0; i < 7; i++)
        begin
            queue_access(1'(i), 48'(age_probe[i]) << 2);
        end

        // same pattern under fifo: the refreshed tag gets evicted this time
        apply_cfg(POLICY_FIFO, 4'd0, 4'd2, 4'd4);
        for (int i = 0; i < 7; i++)
        begin
            queue_access(1'(i + 1), 48'(age_probe[i] + 8) << 2);
        end

        // offset beyond 12, set bits beyond the set count, too many ways
        apply_cfg(POLICY_LRU, 4'd15, 4'd15, 4'd15);
        queue_access(KIND_READ,  48'h0);
        queue_access(KIND_WRITE, 48'hffff_ffff_ffff);
        queue_access(KIND_READ,  48'h8000_0000_0000);

        // zero ways acts as one way
        apply_cfg(POLICY_FIFO, 4'd12, 4'd8, 4'd0);
        queue_access(KIND_WRITE, 48'h0000_0000_1000);
        queue_access(KIND_READ,  48'h0000_0000_1000);

        for (int p = 0; p < 9; p++)
        begin
            apply_cfg(phase_cfg[p][0][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            run_random(70);
            // receiver holds off while the sender keeps offering: input must stall
            if (p == 2)
            begin
                long_hold_req = 1'b1;
            end
        end

        wait_idle();
        if (err_count == 0)
        begin
            $display("tb_set_assoc_cache_lru_fifo: done, clean");
        end
        else
        begin
            $display("tb_set_assoc_cache_lru_fifo: done, errors");
        end
        $finish;
    end

endmodule

// File: set_assoc_cache_lru_fifo.f
sv/salf_pkg.sv
sv/salf_ram.sv
sv/set_assoc_cache_lru_fifo.sv
dv/tb_set_assoc_cache_lru_fifo.sv
